/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an implication holds on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/sppd_pkg.sv */
// ----------------------------------------------------------------------------
// sppd_pkg
// Types, constants and helpers for the stereo ping-pong delay with ducking.
// ----------------------------------------------------------------------------
package sppd_pkg;

  typedef struct packed {
    logic signed [23:0] in_left;
    logic signed [23:0] in_right;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] out_left;
    logic signed [23:0] out_right;
  } out_word_t;

  // Sequencer view handed to the lanes and the ducking unit.
  typedef struct packed {
    logic       adv;
    logic [2:0] step;
  } ctrl_t;

  localparam logic [2:0] STEP_RD0  = 3'd0;
  localparam logic [2:0] STEP_RD1  = 3'd1;
  localparam logic [2:0] STEP_DIFF = 3'd2;
  localparam logic [2:0] STEP_ECHO = 3'd3;
  localparam logic [2:0] STEP_MUL  = 3'd4;
  localparam logic [2:0] STEP_WR   = 3'd5;
  localparam logic [2:0] STEP_WET  = 3'd6;
  localparam logic [2:0] STEP_MIX  = 3'd7;

  localparam logic [2:0] REG_DLY_L   = 3'd0;
  localparam logic [2:0] REG_DLY_R   = 3'd1;
  localparam logic [2:0] REG_FB      = 3'd2;
  localparam logic [2:0] REG_WET     = 3'd3;
  localparam logic [2:0] REG_DEPTH   = 3'd4;
  localparam logic [2:0] REG_MODE    = 3'd5;
  localparam logic [2:0] REG_ATTACK  = 3'd6;
  localparam logic [2:0] REG_RELEASE = 3'd7;

  localparam logic [1:0] MODE_MONO = 2'd1;
  localparam logic [1:0] MODE_PING = 2'd2;

  localparam logic [16:0] UNITY  = 17'd65536;
  localparam logic [16:0] FB_MAX = 17'd62259;

  function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
    logic signed [23:0] r;
    if (v > 44'sd8388607) begin
      r = 24'sd8388607;
    end else if (v < -44'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* src/sppd_duck.sv */
// ----------------------------------------------------------------------------
// sppd_duck
// Peak envelope follower and echo gain, shared by both lanes.
// ----------------------------------------------------------------------------
module sppd_duck (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sppd_pkg::ctrl_t    ctrl_i,
  input  sppd_pkg::in_word_t dry_i,
  input  logic [23:0]        attack_i,
  input  logic [23:0]        release_i,
  input  logic [16:0]        depth_i,
  input  logic [16:0]        wet_i,
  output logic [16:0]        wetg_o
);
  import sppd_pkg::*;

  logic [31:0]        env_q, env_d;
  logic [31:0]        target_q;
  logic signed [32:0] diff_q;
  logic [23:0]        coef_q;
  logic signed [57:0] prod_q;
  logic [16:0]        m_q, m_d;
  logic [33:0]        dm_q;
  logic [16:0]        gain_q, gain_d;
  logic [16:0]        wetg_q;

  logic signed [24:0] abs_l, abs_r;
  logic [23:0]        peak;
  logic [31:0]        target;
  logic signed [57:0] prod_rnd;
  logic signed [34:0] env_sum;
  logic [34:0]        dm_rnd;
  logic [18:0]        dm_r;
  logic [34:0]        wg_full;

  always_comb begin
    abs_l = dry_i.in_left[23] ? -25'(dry_i.in_left) : 25'(dry_i.in_left);
    abs_r = dry_i.in_right[23] ? -25'(dry_i.in_right) : 25'(dry_i.in_right);
    peak  = (abs_l > abs_r) ? abs_l[23:0] : abs_r[23:0];
    target = {peak, 8'd0};

    prod_rnd = (prod_q + 58'sd8388608) >>> 24;
    env_sum  = 35'(signed'({1'b0, target_q})) + prod_rnd[34:0];
    if (env_sum < 0) begin
      env_d = '0;
    end else if (env_sum > 35'sh0FFFFFFFF) begin
      env_d = '1;
    end else begin
      env_d = env_sum[31:0];
    end
    m_d = (env_d[31:13] > 19'(UNITY)) ? UNITY : env_d[29:13];

    dm_rnd = 35'(dm_q) + 35'd32768;
    dm_r   = dm_rnd[34:16];
    gain_d = (dm_r > 19'(UNITY)) ? '0 : 17'(19'(UNITY) - dm_r);

    wg_full = 35'(34'(wet_i) * 34'(gain_q)) + 35'd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (ctrl_i.adv && ctrl_i.step == STEP_DIFF) begin
      env_q <= env_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      case (ctrl_i.step)
        STEP_RD0: begin
          target_q <= target;
          diff_q   <= 33'(env_q) - 33'(target);
          coef_q   <= (target > env_q) ? attack_i : release_i;
        end
        STEP_RD1:  prod_q <= diff_q * signed'({1'b0, coef_q});
        STEP_DIFF: m_q    <= m_d;
        STEP_ECHO: dm_q   <= 34'(depth_i) * 34'(m_q);
        STEP_MUL:  gain_q <= gain_d;
        STEP_WR:   wetg_q <= wg_full[32:16];
        default: ;
      endcase
    end
  end

  assign wetg_o = wetg_q;

endmodule

/* src/sppd_lane.sv */
// ----------------------------------------------------------------------------
// sppd_lane
// One channel: delay line, interpolated tap, feedback write and dry/wet mix.
// ----------------------------------------------------------------------------
module sppd_lane #(
  parameter int unsigned LINE_DEPTH = 131072,
  localparam int unsigned AW = $clog2(LINE_DEPTH)
) (
  input  logic               clk_i,
  input  sppd_pkg::ctrl_t    ctrl_i,
  input  logic [24:0]        dly_i,
  input  logic [AW-1:0]      wpos_i,
  input  logic               wrapped_i,
  input  logic signed [23:0] dry_i,
  input  logic [16:0]        fb_i,
  input  logic [16:0]        dry_gain_i,
  input  logic [16:0]        wetg_i,
  input  logic signed [23:0] echo_x_i,
  output logic signed [23:0] echo_o,
  output logic signed [23:0] mix_o
);
  import sppd_pkg::*;

  localparam int unsigned CW = (AW + 9 > 25) ? AW + 9 : 25;
  localparam logic [CW-1:0] TOTAL = CW'(LINE_DEPTH) << 8;
  localparam logic [CW-1:0] DMAX  = CW'(LINE_DEPTH - 2) << 8;
  localparam logic [CW-1:0] DMIN  = CW'(256);
  localparam logic [AW-1:0] LAST  = AW'(LINE_DEPTH - 1);

  logic [23:0] line_mem [LINE_DEPTH];

  logic [23:0]        rdata_q;
  logic               rvalid_q;
  logic [AW-1:0]      i1_q;
  logic [7:0]         frac_q;
  logic signed [23:0] a_q;
  logic signed [24:0] diff_q;
  logic signed [23:0] echo_q;
  logic signed [40:0] fbp_q;
  logic signed [41:0] dryp_q;
  logic signed [41:0] echop_q;

  logic [CW-1:0]      d_ext, d_cl, base, pos;
  logic [AW-1:0]      i0, i1, raddr;
  logic signed [23:0] rd_val;
  logic signed [33:0] ip_prod;
  logic signed [33:0] ip_rnd;
  logic signed [40:0] fb_rnd;
  logic signed [43:0] w_sum;
  logic               we;
  logic signed [23:0] wdata;
  logic signed [42:0] mix_sum;

  always_comb begin
    d_ext = CW'(dly_i);
    if (d_ext < DMIN) begin
      d_cl = DMIN;
    end else if (d_ext > DMAX) begin
      d_cl = DMAX;
    end else begin
      d_cl = d_ext;
    end
    base  = CW'(wpos_i) << 8;
    pos   = (base >= d_cl) ? base - d_cl : base + TOTAL - d_cl;
    i0    = pos[AW+7:8];
    i1    = (i0 == LAST) ? '0 : i0 + AW'(1);
    raddr = (ctrl_i.step == STEP_RD0) ? i0 : i1_q;

    rd_val  = rvalid_q ? signed'(rdata_q) : '0;
    ip_prod = 34'(diff_q) * 34'(signed'({1'b0, frac_q}));
    ip_rnd  = (ip_prod + 34'sd128) >>> 8;

    fb_rnd = (fbp_q + 41'sd32768) >>> 16;
    w_sum  = 44'(dry_i) + 44'(fb_rnd);
    wdata  = sat24(w_sum);
    we     = ctrl_i.adv && ctrl_i.step == STEP_WR;

    mix_sum = (43'(dryp_q) + 43'(echop_q) + 43'sd32768) >>> 16;
    mix_o   = sat24(44'(mix_sum));
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk_i) begin
    rdata_q  <= line_mem[raddr];
    rvalid_q <= wrapped_i || (raddr < wpos_i);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      line_mem[wpos_i] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      case (ctrl_i.step)
        STEP_RD0: begin
          i1_q   <= i1;
          frac_q <= pos[7:0];
        end
        STEP_RD1:  a_q    <= rd_val;
        STEP_DIFF: diff_q <= 25'(rd_val) - 25'(a_q);
        STEP_ECHO: echo_q <= a_q + ip_rnd[23:0];
        STEP_MUL: begin
          fbp_q  <= 41'(signed'({1'b0, fb_i})) * 41'(echo_x_i);
          dryp_q <= 42'(dry_i) * 42'(signed'({1'b0, dry_gain_i}));
        end
        STEP_WET: echop_q <= 42'(echo_q) * 42'(signed'({1'b0, wetg_i}));
        default: ;
      endcase
    end
  end

  assign echo_o = echo_q;

endmodule

/* src/stereo_pingpong_delay_ducking_unit.sv */
// ----------------------------------------------------------------------------
// stereo_pingpong_delay_ducking_unit
// Stereo delay with fractional taps, ping-pong feedback and echo ducking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one word: a stereo dry sample
//   pair. Output channel out_valid_o/out_ready_i carries one word per input
//   word: the mixed stereo pair. Write registers through cfg_we_i, cfg_idx_i
//   and cfg_data_i only while no word is in flight.
//   Each word runs through an eight-step sequencer. Both channel lanes work
//   side by side; each lane owns one single-port-read delay memory, so the two
//   interpolation taps are read in successive steps, and the feedback write and mix
//   products fill the remaining steps. A new word enters only as the one in
//   flight finishes mixing. The ducking envelope runs alongside in its own unit.
//   The output register decouples the sides: the next word is taken while a
//   result waits. When the receiver stalls, the sequencer holds at its last
//   step until the output register frees up, and input ready drops.
//   Reset clears control state, the envelope and the write head at once. No
//   clearing pass: a write-head fill mark makes unwritten entries read zero.
// ----------------------------------------------------------------------------
module stereo_pingpong_delay_ducking_unit #(
  parameter int unsigned LINE_DEPTH = 131072
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sppd_pkg::in_word_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sppd_pkg::out_word_t out_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [24:0]         cfg_data_i
);
  import sppd_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);

  // Configuration registers.
  logic [24:0] dly_l_q, dly_r_q;
  logic [15:0] fb_q;
  logic [16:0] wet_q, depth_q;
  logic [1:0]  mode_q;
  logic [23:0] attack_q, release_q;

  // Sequencer and line head.
  logic          busy_q;
  logic [2:0]    step_q;
  logic [AW-1:0] wpos_q;
  logic          wrapped_q;
  in_word_t      in_q;
  out_word_t     out_q;
  logic          out_valid_q;

  logic               adv, finish, accept;
  ctrl_t              ctrl;
  logic [16:0]        fb_sat, wet_sat, depth_sat, dry_gain, wetg;
  logic [24:0]        dly_r_sel;
  logic signed [23:0] echo_l, echo_r, mix_l, mix_r;
  logic signed [23:0] x_l, x_r;

  always_comb begin
    // Hold at the last step while the previous result is still unread.
    adv    = busy_q && !(step_q == STEP_MIX && out_valid_q && !out_ready_i);
    finish = adv && step_q == STEP_MIX;
    in_ready_o = !busy_q || finish;
    accept = in_valid_i && in_ready_o;
    ctrl.adv  = adv;
    ctrl.step = step_q;

    fb_sat    = (17'(fb_q) > FB_MAX) ? FB_MAX : 17'(fb_q);
    wet_sat   = (wet_q > UNITY) ? UNITY : wet_q;
    depth_sat = (depth_q > UNITY) ? UNITY : depth_q;
    dry_gain  = UNITY - wet_sat;
    dly_r_sel = (mode_q == MODE_MONO) ? dly_l_q : dly_r_q;
    // Cross the feedback paths in ping-pong mode.
    x_l = (mode_q == MODE_PING) ? echo_r : echo_l;
    x_r = (mode_q == MODE_PING) ? echo_l : echo_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_l_q   <= 25'd256;
      dly_r_q   <= 25'd256;
      fb_q      <= '0;
      wet_q     <= '0;
      depth_q   <= '0;
      mode_q    <= '0;
      attack_q  <= 24'd16707456;
      release_q <= 24'd16774886;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DLY_L:   dly_l_q   <= cfg_data_i;
        REG_DLY_R:   dly_r_q   <= cfg_data_i;
        REG_FB:      fb_q      <= cfg_data_i[15:0];
        REG_WET:     wet_q     <= cfg_data_i[16:0];
        REG_DEPTH:   depth_q   <= cfg_data_i[16:0];
        REG_MODE:    mode_q    <= cfg_data_i[1:0];
        REG_ATTACK:  attack_q  <= cfg_data_i[23:0];
        REG_RELEASE: release_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_RD0;
      wpos_q      <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Advance the sequencer; a new word restarts it at the first read.
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= STEP_RD0;
      end else if (finish) begin
        busy_q <= 1'b0;
        step_q <= STEP_RD0;
      end else if (adv) begin
        step_q <= step_q + 3'd1;
      end
      // Move the write head once per word, after the line write.
      if (adv && step_q == STEP_WR) begin
        if (wpos_q == LAST) begin
          wpos_q    <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wpos_q <= wpos_q + AW'(1);
        end
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    if (finish) begin
      out_q.out_left  <= mix_l;
      out_q.out_right <= mix_r;
    end
  end

  sppd_duck u_duck (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .dry_i     (in_q),
    .attack_i  (attack_q),
    .release_i (release_q),
    .depth_i   (depth_sat),
    .wet_i     (wet_sat),
    .wetg_o    (wetg)
  );

  sppd_lane #(.LINE_DEPTH(LINE_DEPTH)) u_lane_l (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .dly_i      (dly_l_q),
    .wpos_i     (wpos_q),
    .wrapped_i  (wrapped_q),
    .dry_i      (in_q.in_left),
    .fb_i       (fb_sat),
    .dry_gain_i (dry_gain),
    .wetg_i     (wetg),
    .echo_x_i   (x_l),
    .echo_o     (echo_l),
    .mix_o      (mix_l)
  );

  sppd_lane #(.LINE_DEPTH(LINE_DEPTH)) u_lane_r (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .dly_i      (dly_r_sel),
    .wpos_i     (wpos_q),
    .wrapped_i  (wrapped_q),
    .dry_i      (in_q.in_right),
    .fb_i       (fb_sat),
    .dry_gain_i (dry_gain),
    .wetg_i     (wetg),
    .echo_x_i   (x_r),
    .echo_o     (echo_r),
    .mix_o      (mix_r)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_out_from_mix, $rose(out_valid_q) |-> $past(step_q) == STEP_MIX, "result without mix step")
  `ASSERT_IMPL(a_wpos_step, adv && step_q == STEP_WR, wpos_q == (($past(wpos_q) == LAST) ? '0 : $past(wpos_q) + AW'(1)), "write head slip")
  `ASSERT_IMPL(a_wrap_sticky, wrapped_q, wrapped_q, "fill mark cleared")

endmodule

/* tb/tb_stereo_pingpong_delay_ducking_unit.sv */
// ----------------------------------------------------------------------------
// tb_stereo_pingpong_delay_ducking_unit
// Self-checking bench: drives stereo words through the delay unit under
// several register settings and idling phases, predicts every output word
// with a cycle-free model of the delay lines and ducking envelope, and
// compares in order.
// ----------------------------------------------------------------------------
module tb_stereo_pingpong_delay_ducking_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sppd_pkg::*;

  localparam int unsigned DEPTH = 131072;
  localparam longint MAX_CYCLES = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [24:0] cfg_data_i = '0;

  stereo_pingpong_delay_ducking_unit #(.LINE_DEPTH(DEPTH)) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: lines, write head, envelope and register copies.
  logic signed [23:0] left_mem [DEPTH];
  logic signed [23:0] right_mem [DEPTH];
  int unsigned head;
  longint envelope;
  longint regs [8];

  out_word_t pending_q [$];
  int errors = 0;
  int n_mismatch = 0;
  longint cycle = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  function automatic longint round_shift(longint v, int s);
    v += longint'(1) << (s - 1);
    if (v >= 0) return v >>> s;
    return -((-v + (longint'(1) << s) - 1) >>> s);
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint tap_read(bit right_side, longint dly);
    longint dmax, total, base, pos, a, b, frac;
    int unsigned i0, i1;
    dmax = (longint'(DEPTH) - 2) * 256;
    total = longint'(DEPTH) * 256;
    base = longint'(head) * 256;
    if (dly < 256) dly = 256;
    if (dly > dmax) dly = dmax;
    pos = (base >= dly) ? base - dly : base + total - dly;
    i0 = 32'((pos >> 8) % DEPTH);
    frac = pos & 255;
    i1 = (i0 + 1 >= DEPTH) ? 0 : i0 + 1;
    a = right_side ? right_mem[i0] : left_mem[i0];
    b = right_side ? right_mem[i1] : left_mem[i1];
    return a + round_shift((b - a) * frac, 8);
  endfunction

  function automatic void predictor_reset();
    foreach (left_mem[i]) begin
      left_mem[i] = '0;
      right_mem[i] = '0;
    end
    head = 0;
    envelope = 0;
    regs = '{256, 256, 0, 0, 0, 0, 16707456, 16774886};
  endfunction

  // Compute the mixed output word for one dry pair and advance the model.
  function automatic out_word_t predict_mix(in_word_t w);
    longint dl, dr, al, ar, target, coef, m, depth, gain, fb, el, er, wl, wr;
    longint wet, wetg;
    out_word_t r;
    dl = w.in_left;
    dr = w.in_right;
    al = dl < 0 ? -dl : dl;
    ar = dr < 0 ? -dr : dr;
    target = (al > ar ? al : ar) * 256;
    coef = (target > envelope) ? regs[REG_ATTACK] : regs[REG_RELEASE];
    envelope = target + round_shift((envelope - target) * coef, 24);
    if (envelope < 0) envelope = 0;
    if (envelope > 64'hFFFFFFFF) envelope = 64'hFFFFFFFF;
    m = envelope >> 13;
    if (m > UNITY) m = UNITY;
    depth = regs[REG_DEPTH] > UNITY ? UNITY : regs[REG_DEPTH];
    gain = UNITY - round_shift(depth * m, 16);
    if (gain < 0) gain = 0;
    el = tap_read(1'b0, regs[REG_DLY_L]);
    er = tap_read(1'b1, regs[REG_MODE] == MODE_MONO ? regs[REG_DLY_L] : regs[REG_DLY_R]);
    fb = regs[REG_FB] > FB_MAX ? FB_MAX : regs[REG_FB];
    if (regs[REG_MODE] == MODE_PING) begin
      wl = dl + round_shift(fb * er, 16);
      wr = dr + round_shift(fb * el, 16);
    end else begin
      wl = dl + round_shift(fb * el, 16);
      wr = dr + round_shift(fb * er, 16);
    end
    left_mem[head] = clip24(wl);
    right_mem[head] = clip24(wr);
    head = (head + 1 >= DEPTH) ? 0 : head + 1;
    wet = regs[REG_WET] > UNITY ? UNITY : regs[REG_WET];
    wetg = round_shift(wet * gain, 16);
    r.out_left = clip24(round_shift(dl * (UNITY - wet) + el * wetg, 16));
    r.out_right = clip24(round_shift(dr * (UNITY - wet) + er * wetg, 16));
    return r;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when requested.
  always @(posedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Check every accepted output word against the oldest expectation.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (n_mismatch++ < 10) $display("unexpected output word %h", out_o);
      end else begin
        want = pending_q.pop_front();
        if (out_o.out_left !== want.out_left || out_o.out_right !== want.out_right) begin
          errors++;
          if (n_mismatch++ < 10)
            $display("mismatch at cycle %0d: expected L %0d R %0d, got L %0d R %0d",
                     cycle, want.out_left, want.out_right, out_o.out_left, out_o.out_right);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[24:0];
    regs[idx] = val & ((longint'(1) << 25) - 1);
    case (idx) inside
      REG_FB: regs[idx] &= 16'hFFFF;
      REG_WET, REG_DEPTH: regs[idx] &= 17'h1FFFF;
      REG_MODE: regs[idx] &= 2'h3;
      REG_ATTACK, REG_RELEASE: regs[idx] &= 24'hFFFFFF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one word; hold it until accepted, then drop valid.
  task automatic send_word(in_word_t w, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_i <= w;
    pending_q.push_back(predict_mix(w));
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge
    if (last) in_valid_i <= 1'b0;
    else begin
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    case ($urandom_range(9))
      0: w = {24'sh7FFFFF, 24'sh800000};
      1: w = {24'sh800000, 24'sh7FFFFF};
      2: begin
        w.in_left = 24'($signed(24'($urandom_range(4095))) - 2048);
        w.in_right = 24'($signed(24'($urandom_range(4095))) - 2048);
      end
      default: w = {24'($urandom), 24'($urandom)};
    endcase
    return w;
  endfunction

  // Directed rows: dry pair, and an expected word where it is obvious.
  typedef struct {
    logic signed [23:0] l;
    logic signed [23:0] r;
    bit has_want;
  } row_t;

  row_t dir_tab [] = '{
    '{24'sd0, 24'sd0, 1'b1},
    '{24'sd8388607, 24'sd8388607, 1'b1},
    '{-24'sd8388608, -24'sd8388608, 1'b1},
    '{24'sd8388607, -24'sd8388608, 1'b1},
    '{24'sd1, -24'sd1, 1'b1},
    '{24'sd12345, 24'sd0, 1'b1}
  };

  initial begin
    in_word_t w;
    predictor_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset wet is zero, so each output equals its dry input.
    foreach (dir_tab[i]) begin
      w = {dir_tab[i].l, dir_tab[i].r};
      send_word(w, 1'b1);
      if (dir_tab[i].has_want && pending_q[$] !== w) begin
        errors++;
        $display("predictor disagrees with dry pass-through at row %0d", i);
      end
    end
    drain();

    // Extremes of every register, with unknown/out-of-range values too.
    write_reg(REG_DLY_L, 0);
    write_reg(REG_DLY_R, 25'h1FFFFFF);
    write_reg(REG_FB, 16'hFFFF);
    write_reg(REG_WET, 17'h1FFFF);
    write_reg(REG_DEPTH, 17'h1FFFF);
    write_reg(REG_MODE, 3);
    write_reg(REG_ATTACK, 0);
    write_reg(REG_RELEASE, 24'hFFFFFF);
    repeat (6) send_word({24'sh7FFFFF, 24'sh800000}, 1'b1);
    repeat (6) send_word({24'sd0, 24'sd0}, 1'b1);
    drain();

    // Random phases, each with new settings and an idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      write_reg(REG_DLY_L, $urandom_range(256, 256 * 40));
      write_reg(REG_DLY_R, (ph == 5) ? 33553920 : $urandom_range(256, 256 * 40));
      write_reg(REG_FB, (ph == 3) ? 62259 : $urandom_range(65535));
      write_reg(REG_WET, (ph == 2) ? 65536 : $urandom_range(65536));
      write_reg(REG_DEPTH, (ph == 6) ? 0 : $urandom_range(65536));
      write_reg(REG_MODE, ph % 4);
      write_reg(REG_ATTACK, $urandom_range(24'hFFFFFF));
      write_reg(REG_RELEASE, (ph == 1) ? 0 : $urandom_range(24'hFFFFFF));
      for (int k = 0; k < 125; k++) begin
        if (ph == 4 && k == 30) begin
          recv_hold = 1'b1;
          fork
            begin repeat (300) @(posedge clk_i); recv_hold = 1'b0; end
          join_none
        end
        if (ph == 6 && k == 60) drain();
        send_word(rand_word(), 1'b1);
      end
      drain();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
